// ----- sv/maf_pkg.sv -----
package maf_pkg;

  // geometry
  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int REG_BITS     = 5;
  localparam int WINDOW_MIN   = 2;
  localparam int WINDOW_RESET = 8;

  localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int POS_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int CNT_BITS   = $clog2(SUM_BITS);
  localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = CFG_ADDR_BITS - 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = '0;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic update_sum;
    logic load_div;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath status
  typedef struct packed {
    logic [WIN_BITS-1:0] window;
    logic [POS_BITS-1:0] pos;
  } stat_t;

  function automatic logic [WIN_BITS-1:0] clamp_window(input logic [REG_BITS-1:0] v);
    int unsigned val;
    int unsigned res;
    val = int'(v);
    if (val < WINDOW_MIN) begin
      res = WINDOW_MIN;
    end else if (val > MAX_WINDOW) begin
      res = MAX_WINDOW;
    end else begin
      res = val;
    end
    return WIN_BITS'(res);
  endfunction

endpackage

// ----- sv/maf_ctrl.sv -----
module maf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output maf_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [maf_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        cmd.update_sum = 1'b1;
        state_nxt      = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_div = 1'b1;
        cnt_nxt      = maf_pkg::CNT_BITS'(maf_pkg::SUM_BITS - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/maf_dpath.sv -----
module maf_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  maf_pkg::cmd_t                        cmd,
  input  logic                                 cfg_we,
  input  logic [maf_pkg::REG_BITS-1:0]         cfg_wdata,
  input  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample,
  output logic [maf_pkg::SAMPLE_BITS-1:0]      average,
  output maf_pkg::stat_t                       stat
);

  logic [maf_pkg::WIN_BITS-1:0]          window_r;
  logic [maf_pkg::POS_BITS-1:0]          pos_r;
  logic signed [maf_pkg::SUM_BITS-1:0]   sum_r;
  logic [maf_pkg::MAX_WINDOW-1:0]        valid_r;
  logic signed [maf_pkg::SAMPLE_BITS-1:0] store_r [maf_pkg::MAX_WINDOW];
  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample_r;
  logic [maf_pkg::SUM_BITS-1:0]          quot_r;
  logic [maf_pkg::WIN_BITS-1:0]          rem_r;
  logic                                  neg_r;
  logic [maf_pkg::SAMPLE_BITS-1:0]       avg_r;

  logic signed [maf_pkg::SAMPLE_BITS-1:0] old_val;
  logic signed [maf_pkg::SUM_BITS-1:0]   sum_nxt;
  logic [maf_pkg::WIN_BITS-1:0]          pos_inc;
  logic [maf_pkg::POS_BITS-1:0]          pos_nxt;
  logic [maf_pkg::SUM_BITS-1:0]          sum_mag;
  logic [maf_pkg::WIN_BITS:0]            part;
  logic [maf_pkg::WIN_BITS:0]            trial;
  logic [maf_pkg::SUM_BITS-1:0]          quot_signed;

  // oldest entry, never-written slots read as zero
  assign old_val = valid_r[pos_r] ? store_r[pos_r] : '0;
  assign sum_nxt = sum_r - maf_pkg::SUM_BITS'(old_val) + maf_pkg::SUM_BITS'(sample_r);

  assign pos_inc = maf_pkg::WIN_BITS'(pos_r) + 1'b1;
  assign pos_nxt = (pos_inc >= window_r) ? '0 : pos_inc[maf_pkg::POS_BITS-1:0];

  assign sum_mag = sum_r[maf_pkg::SUM_BITS-1] ? (~sum_r + 1'b1) : sum_r;

  // restoring divide step, one quotient bit per cycle
  assign part  = {rem_r, quot_r[maf_pkg::SUM_BITS-1]};
  assign trial = part - {1'b0, window_r};

  assign quot_signed = neg_r ? (~quot_r + 1'b1) : quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= maf_pkg::clamp_window(maf_pkg::REG_BITS'(maf_pkg::WINDOW_RESET));
      pos_r    <= '0;
      sum_r    <= '0;
      valid_r  <= '0;
    end else if (cfg_we) begin
      window_r <= maf_pkg::clamp_window(cfg_wdata);
      pos_r    <= '0;
      sum_r    <= '0;
      valid_r  <= '0;
    end else if (cmd.update_sum) begin
      sum_r          <= sum_nxt;
      pos_r          <= pos_nxt;
      valid_r[pos_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample;
    end
    if (cmd.update_sum) begin
      store_r[pos_r] <= sample_r;
    end
    if (cmd.load_div) begin
      quot_r <= sum_mag;
      rem_r  <= '0;
      neg_r  <= sum_r[maf_pkg::SUM_BITS-1];
    end else if (cmd.div_step) begin
      if (!trial[maf_pkg::WIN_BITS]) begin
        rem_r  <= trial[maf_pkg::WIN_BITS-1:0];
        quot_r <= {quot_r[maf_pkg::SUM_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= part[maf_pkg::WIN_BITS-1:0];
        quot_r <= {quot_r[maf_pkg::SUM_BITS-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      avg_r <= quot_signed[maf_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign average     = avg_r;
  assign stat.window = window_r;
  assign stat.pos    = pos_r;

endmodule

// ----- sv/moving_average_filter.sv -----
// channel   direction  transfer when                     payload
// in_*      sink       in_tvalid & in_tready             tdata[15:0] sample (signed)
// out_*     source     out_tvalid & out_tready           tdata[15:0] average (signed)
// cfg_*     apb slave  psel & penable & pwrite & pready  reg 0 at 0x0: window_length
//
// one sample at a time, with the restoring divider resolving
// one of the 21 quotient bits per cycle
// a waiting result sits in the output register while the next sample is taken in
// a stalled output holds the datapath in its final state until the register frees
// rst_n is synchronous; it sets window_length to 8 and clears the sample store,
// write position and running sum (a window write clears the same three)
module moving_average_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [maf_pkg::TDATA_BITS-1:0]      in_tdata,   // [15:0] sample
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [maf_pkg::TDATA_BITS-1:0]      out_tdata,  // [15:0] average
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [maf_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [maf_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [maf_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready
);

  maf_pkg::cmd_t                    cmd;
  maf_pkg::stat_t                   stat;
  logic                             cfg_sel_win;
  logic                             cfg_we;
  logic [maf_pkg::SAMPLE_BITS-1:0]  average;

  // register decode, word addressed
  assign cfg_pready  = 1'b1;
  assign cfg_sel_win = (cfg_paddr[maf_pkg::CFG_ADDR_BITS-1:2] == maf_pkg::REG_WINDOW);
  assign cfg_we      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_win;
  assign cfg_prdata  = cfg_sel_win ? maf_pkg::CFG_DATA_BITS'(stat.window) : '0;

  // sequencer: capture, sum update, divider load, divide, result hand-off
  maf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  // store, running sum, divider and output register
  maf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_pwdata[maf_pkg::REG_BITS-1:0]),
    .sample    (signed'(in_tdata[maf_pkg::SAMPLE_BITS-1:0])),
    .average   (average),
    .stat      (stat)
  );

  assign out_tdata = maf_pkg::TDATA_BITS'(average);

  // one sample in flight: no second transfer right behind the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a sample is in flight");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("output register reloaded while stalled");

  // write position stays inside the window
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pos < stat.window)
    else $error("write position outside window");

  // window write lands inside the legal range
  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (stat.window >= maf_pkg::WIN_BITS'(maf_pkg::WINDOW_MIN))
            && (stat.window <= maf_pkg::WIN_BITS'(maf_pkg::MAX_WINDOW)))
    else $error("window length out of range");

endmodule
